// ===== src/tolerance_leader_clustering_core_defines.svh =====
// Assertion macros shared by the clustering core.
`ifndef TOLERANCE_LEADER_CLUSTERING_CORE_DEFINES_SVH
`define TOLERANCE_LEADER_CLUSTERING_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TLC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define TLC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/tlc_pkg.sv =====
// Types and constants shared by the clustering core and its compare unit.
`default_nettype none
package tlc_pkg;
   localparam int MASS_W      = 36;
   localparam int TIME_W      = 32;
   localparam int INT_W       = 40;
   localparam int SUM_W       = 48;
   localparam int ID_W        = 5;
   localparam int ID_SLOTS    = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 36;

   localparam logic [CSR_INDEX_W-1:0] CSR_MASS_TOL = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIME_TOL = 2'd1;

   localparam logic [MASS_W-1:0] MASS_TOL_RESET = 36'd6554;
   localparam logic [TIME_W-1:0] TIME_TOL_RESET = 32'd3932160;

   typedef struct packed {
      logic [MASS_W-1:0] value_a;
      logic [MASS_W-1:0] value_b;
      logic [MASS_W-1:0] tolerance;
   } tlc_match_req_type;
endpackage
`default_nettype wire

// ===== src/tlc_match_unit.sv =====
// Shared tolerance compare unit: absolute difference against a limit.
`default_nettype none
module tlc_match_unit
   import tlc_pkg::*;
(
   input  tlc_match_req_type req,
   output logic              in_range
);
   logic [MASS_W-1:0] diff;

   always_comb begin
      if (req.value_a >= req.value_b) begin
         diff = req.value_a - req.value_b;
      end else begin
         diff = req.value_b - req.value_a;
      end
      in_range = (diff <= req.tolerance);
   end
endmodule
`default_nettype wire

// ===== src/tolerance_leader_clustering_core.sv =====
// Top level of the tolerance leader clustering core.
// A feature is taken when start is high and busy is low. The core then checks the
// open clusters' leaders one at a time with a single compare unit that tests mass
// and then time, with a read, a mass compare and a time compare state per leader.
// With end_of_set, every open cluster total follows, read one by one from the
// total memory, each with a read state and an output state.
// Each result word sits on the rsp_ ports for exactly one cycle with rsp_valid
// high; the receiver cannot stall and must take every word as it appears.
`default_nettype none
`include "tolerance_leader_clustering_core_defines.svh"
module tolerance_leader_clustering_core
   import tlc_pkg::*;
#(
   parameter int MAX_CLUSTERS = 32
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   output logic                   busy,
   input  wire [MASS_W-1:0]       req_feature_mass,
   input  wire [TIME_W-1:0]       req_feature_time,
   input  wire [INT_W-1:0]        req_feature_intensity,
   input  wire                    req_end_of_set,
   output logic                   rsp_valid,
   output logic                   rsp_result_kind,
   output logic [ID_W-1:0]        rsp_cluster_index,
   output logic [SUM_W-1:0]       rsp_total_intensity,
   output logic                   rsp_table_full,
   output logic                   rsp_last_of_run,
   input  wire                    csr_valid,
   output logic                   csr_ready,
   input  wire [CSR_INDEX_W-1:0]  csr_index,
   input  wire [CSR_DATA_W-1:0]   csr_data
);
   localparam int SLOTS = (MAX_CLUSTERS < ID_SLOTS) ? MAX_CLUSTERS : ID_SLOTS;
   localparam int IW    = $clog2(SLOTS);
   localparam int UW    = $clog2(SLOTS + 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_RD, ST_CMPM, ST_CMPT, ST_SUM, ST_NEW, ST_REP_RD, ST_REP_OUT
   } state_type;

   state_type         state_ff, state_in;
   logic [IW-1:0]     idx_ff, idx_in;
   logic [UW-1:0]     used_ff, used_in;
   logic              mass_ok_ff, mass_ok_in;
   logic [MASS_W-1:0] mass_ff, mass_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic [INT_W-1:0]  inten_ff, inten_in;
   logic              end_ff, end_in;
   logic [MASS_W-1:0] mass_tol_ff, mass_tol_in;
   logic [TIME_W-1:0] time_tol_ff, time_tol_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_kind_ff, rsp_kind_in;
   logic [ID_W-1:0]   rsp_index_ff, rsp_index_in;
   logic [SUM_W-1:0]  rsp_total_ff, rsp_total_in;
   logic              rsp_full_ff, rsp_full_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [MASS_W-1:0] lead_mass_mem [SLOTS];
   logic [TIME_W-1:0] lead_time_mem [SLOTS];
   logic [SUM_W-1:0]  sum_mem [SLOTS];
   logic [MASS_W-1:0] lm_q_ff;
   logic [TIME_W-1:0] lt_q_ff;
   logic [SUM_W-1:0]  sum_q_ff;

   tlc_match_req_type match_req;
   logic              in_range;
   logic [SUM_W:0]    sum_ext;
   logic [SUM_W-1:0]  sum_sat;
   logic [IW-1:0]     wr_addr;
   logic              lead_we;
   logic              sum_we;
   logic [SUM_W-1:0]  sum_wdata;

   always_comb begin
      match_req.value_a   = mass_ff;
      match_req.value_b   = lm_q_ff;
      match_req.tolerance = mass_tol_ff;
      if (state_ff == ST_CMPT) begin
         match_req.value_a   = {{(MASS_W-TIME_W){1'b0}}, time_ff};
         match_req.value_b   = {{(MASS_W-TIME_W){1'b0}}, lt_q_ff};
         match_req.tolerance = {{(MASS_W-TIME_W){1'b0}}, time_tol_ff};
      end
   end

   tlc_match_unit u_match (
      .req      (match_req),
      .in_range (in_range)
   );

   always_comb begin
      sum_ext = {1'b0, sum_q_ff} + {{(SUM_W+1-INT_W){1'b0}}, inten_ff};
      sum_sat = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
      wr_addr = (state_ff == ST_NEW) ? used_ff[IW-1:0] : idx_ff;
      lead_we = (state_ff == ST_NEW) && (used_ff < UW'(SLOTS));
      sum_we  = lead_we || (state_ff == ST_SUM);
      sum_wdata = (state_ff == ST_NEW) ? {{(SUM_W-INT_W){1'b0}}, inten_ff} : sum_sat;
   end

   always_ff @(posedge clock) begin
      if (lead_we) begin
         lead_mass_mem[wr_addr] <= mass_ff;
         lead_time_mem[wr_addr] <= time_ff;
      end
      if (sum_we) begin
         sum_mem[wr_addr] <= sum_wdata;
      end
      lm_q_ff  <= lead_mass_mem[idx_ff];
      lt_q_ff  <= lead_time_mem[idx_ff];
      sum_q_ff <= sum_mem[idx_ff];
   end

   always_comb begin
      logic [UW-1:0] used_new;
      used_new     = used_ff;
      state_in     = state_ff;
      idx_in       = idx_ff;
      used_in      = used_ff;
      mass_ok_in   = mass_ok_ff;
      mass_in      = mass_ff;
      time_in      = time_ff;
      inten_in     = inten_ff;
      end_in       = end_ff;
      mass_tol_in  = mass_tol_ff;
      time_tol_in  = time_tol_ff;
      rsp_valid_in = 1'b0;
      rsp_kind_in  = rsp_kind_ff;
      rsp_index_in = rsp_index_ff;
      rsp_total_in = rsp_total_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               mass_in  = req_feature_mass;
               time_in  = req_feature_time;
               inten_in = req_feature_intensity;
               end_in   = req_end_of_set;
               idx_in   = '0;
               state_in = (used_ff == '0) ? ST_NEW : ST_RD;
            end
         end
         ST_RD: begin
            state_in = ST_CMPM;
         end
         ST_CMPM: begin
            mass_ok_in = in_range;
            state_in   = ST_CMPT;
         end
         ST_CMPT: begin
            if (mass_ok_ff && in_range) begin
               state_in = ST_SUM;
            end else if (UW'(idx_ff) + UW'(1) == used_ff) begin
               state_in = ST_NEW;
            end else begin
               idx_in   = idx_ff + IW'(1);
               state_in = ST_RD;
            end
         end
         ST_SUM: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = 1'b0;
            rsp_index_in = ID_W'(idx_ff);
            rsp_total_in = '0;
            rsp_full_in  = 1'b0;
            rsp_last_in  = !end_ff;
            if (end_ff) begin
               idx_in   = '0;
               state_in = ST_REP_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_NEW: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = 1'b0;
            rsp_total_in = '0;
            if (used_ff < UW'(SLOTS)) begin
               used_new     = used_ff + UW'(1);
               rsp_index_in = ID_W'(used_ff);
               rsp_full_in  = 1'b0;
            end else begin
               rsp_index_in = '0;
               rsp_full_in  = 1'b1;
            end
            used_in     = used_new;
            rsp_last_in = !end_ff || (used_new == '0);
            if (end_ff && (used_new != '0)) begin
               idx_in   = '0;
               state_in = ST_REP_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_REP_RD: begin
            state_in = ST_REP_OUT;
         end
         ST_REP_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = 1'b1;
            rsp_index_in = ID_W'(idx_ff);
            rsp_total_in = sum_q_ff;
            rsp_full_in  = 1'b0;
            rsp_last_in  = (UW'(idx_ff) + UW'(1) == used_ff);
            if (UW'(idx_ff) + UW'(1) == used_ff) begin
               used_in  = '0;
               state_in = ST_IDLE;
            end else begin
               idx_in   = idx_ff + IW'(1);
               state_in = ST_REP_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (csr_valid) begin
         case (csr_index)
            CSR_MASS_TOL: mass_tol_in = csr_data[MASS_W-1:0];
            CSR_TIME_TOL: time_tol_in = csr_data[TIME_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         mass_tol_ff  <= MASS_TOL_RESET;
         time_tol_ff  <= TIME_TOL_RESET;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         mass_tol_ff  <= mass_tol_in;
         time_tol_ff  <= time_tol_in;
         idx_ff       <= idx_in;
         mass_ok_ff   <= mass_ok_in;
         mass_ff      <= mass_in;
         time_ff      <= time_in;
         inten_ff     <= inten_in;
         end_ff       <= end_in;
         rsp_kind_ff  <= rsp_kind_in;
         rsp_index_ff <= rsp_index_in;
         rsp_total_ff <= rsp_total_in;
         rsp_full_ff  <= rsp_full_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign busy                = (state_ff != ST_IDLE);
   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_kind     = rsp_kind_ff;
   assign rsp_cluster_index   = rsp_index_ff;
   assign rsp_total_intensity = rsp_total_ff;
   assign rsp_table_full      = rsp_full_ff;
   assign rsp_last_of_run     = rsp_last_ff;

   `TLC_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accepted word did not raise busy")
   `TLC_ASSERT_IMPL(a_used_bound, clock, reset, 1'b1, used_ff <= UW'(SLOTS), "cluster count past capacity")
   `TLC_ASSERT_IMPL(a_full_only_when_full, clock, reset, rsp_valid && rsp_table_full, used_ff == UW'(SLOTS), "table full word with free slots")
   `TLC_ASSERT_IMPL(a_report_clears, clock, reset, rsp_valid && rsp_result_kind && rsp_last_of_run, used_ff == '0, "table not cleared after last report")
endmodule
`default_nettype wire

// ===== dv/cluster_check_pkg.sv =====
// Expected cluster word predictor and scoreboard for the clustering core testbench.
`timescale 1ns / 100ps
package cluster_check_pkg;
   import tlc_pkg::*;

   typedef enum logic {
      KIND_ASSIGN = 1'b0,
      KIND_TOTAL  = 1'b1
   } word_kind_type;

   typedef struct packed {
      word_kind_type     kind;
      logic [ID_W-1:0]   index;
      logic [SUM_W-1:0]  total;
      logic              full;
      logic              last;
   } cluster_word_type;

   class cluster_scoreboard;
      int                slots;
      logic [MASS_W-1:0] mass_tol;
      logic [TIME_W-1:0] time_tol;
      logic [MASS_W-1:0] leader_mass [ID_SLOTS];
      logic [TIME_W-1:0] leader_time [ID_SLOTS];
      logic [SUM_W-1:0]  cluster_total [ID_SLOTS];
      int                open_clusters;
      cluster_word_type  words_due [$];
      int                mismatches;

      function new(int max_clusters);
         slots = (max_clusters < ID_SLOTS) ? max_clusters : ID_SLOTS;
         mass_tol = MASS_TOL_RESET;
         time_tol = TIME_TOL_RESET;
         open_clusters = 0;
         mismatches = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index,
                                   logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_MASS_TOL: mass_tol = data[MASS_W-1:0];
            CSR_TIME_TOL: time_tol = data[TIME_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return words_due.size();
      endfunction

      function void queue_word(cluster_word_type word);
         words_due = {words_due, word};
      endfunction

      function void note_feature(logic [MASS_W-1:0] mass, logic [TIME_W-1:0] rt,
                                 logic [INT_W-1:0] inten, logic eos);
         logic [MASS_W-1:0] mass_gap;
         logic [TIME_W-1:0] time_gap;
         logic [SUM_W:0]    sum;
         cluster_word_type  word;
         int                id;
         bit                found;
         bit                full;
         id = 0;
         found = 0;
         full = 0;
         for (int i = 0; i < open_clusters && !found; i++) begin
            mass_gap = (mass >= leader_mass[i]) ? mass - leader_mass[i] : leader_mass[i] - mass;
            time_gap = (rt >= leader_time[i]) ? rt - leader_time[i] : leader_time[i] - rt;
            if (mass_gap <= mass_tol && time_gap <= time_tol) begin
               found = 1;
               id = i;
            end
         end
         if (found) begin
            sum = {1'b0, cluster_total[id]} + (SUM_W+1)'(inten);
            cluster_total[id] = sum[SUM_W] ? '1 : sum[SUM_W-1:0];
         end else if (open_clusters < slots) begin
            id = open_clusters;
            leader_mass[id] = mass;
            leader_time[id] = rt;
            cluster_total[id] = SUM_W'(inten);
            open_clusters++;
         end else begin
            full = 1;
         end
         word.kind = KIND_ASSIGN;
         word.index = id[ID_W-1:0];
         word.total = '0;
         word.full = full;
         word.last = !eos || open_clusters == 0;
         queue_word(word);
         if (eos) begin
            for (int i = 0; i < open_clusters; i++) begin
               word.kind = KIND_TOTAL;
               word.index = i[ID_W-1:0];
               word.total = cluster_total[i];
               word.full = 1'b0;
               word.last = (i + 1 == open_clusters);
               queue_word(word);
            end
            open_clusters = 0;
         end
      endfunction

      function void check_word(cluster_word_type got);
         cluster_word_type want;
         if (words_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("cluster word error at %0t: unexpected kind %0d index %0d total %0h",
                        $time, got.kind, got.index, got.total);
            return;
         end
         want = words_due.pop_front();
         if (got.kind !== want.kind || got.index !== want.index ||
             got.total !== want.total || got.full !== want.full ||
             got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"cluster word error at %0t: expected kind %0d index %0d total %0h",
                         " full %0d last %0d, got kind %0d index %0d total %0h",
                         " full %0d last %0d"},
                        $time, want.kind, want.index, want.total, want.full, want.last,
                        got.kind, got.index, got.total, got.full, got.last);
         end
      endfunction
   endclass
endpackage

// ===== dv/tb_top.sv =====
// Top-level testbench that drives and checks the tolerance leader clustering core.
`timescale 1ns / 100ps
module tb_top;
   import tlc_pkg::*;
   import cluster_check_pkg::*;

   localparam int          MAX_CLUSTERS = 32;
   localparam int          CYCLE_LIMIT  = 1000000;
   localparam logic [63:0] MASS_MASK    = (64'd1 << MASS_W) - 1;
   localparam logic [63:0] TIME_MASK    = (64'd1 << TIME_W) - 1;
   localparam logic [63:0] INT_MASK     = (64'd1 << INT_W) - 1;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic [MASS_W-1:0]      req_feature_mass = '0;
   logic [TIME_W-1:0]      req_feature_time = '0;
   logic [INT_W-1:0]       req_feature_intensity = '0;
   logic                   req_end_of_set = 1'b0;
   logic                   csr_valid = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;
   logic                   busy;
   logic                   csr_ready;
   logic                   rsp_valid;
   logic                   rsp_result_kind;
   logic [ID_W-1:0]        rsp_cluster_index;
   logic [SUM_W-1:0]       rsp_total_intensity;
   logic                   rsp_table_full;
   logic                   rsp_last_of_run;

   cluster_scoreboard board;
   int                cycle_count = 0;
   int                items_sent = 0;
   bit                no_gaps = 0;

   tolerance_leader_clustering_core #(
      .MAX_CLUSTERS(MAX_CLUSTERS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_feature_mass(req_feature_mass),
      .req_feature_time(req_feature_time),
      .req_feature_intensity(req_feature_intensity),
      .req_end_of_set(req_end_of_set),
      .rsp_valid(rsp_valid),
      .rsp_result_kind(rsp_result_kind),
      .rsp_cluster_index(rsp_cluster_index),
      .rsp_total_intensity(rsp_total_intensity),
      .rsp_table_full(rsp_table_full),
      .rsp_last_of_run(rsp_last_of_run),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tolerance_leader_clustering_core: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      cluster_word_type got;
      if (!reset && rsp_valid === 1'b1) begin
         got.kind = word_kind_type'(rsp_result_kind);
         got.index = rsp_cluster_index;
         got.total = rsp_total_intensity;
         got.full = rsp_table_full;
         got.last = rsp_last_of_run;
         board.check_word(got);
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] near_value(logic [63:0] center, logic [63:0] tol,
                                              logic [63:0] limit);
      logic [63:0] off;
      int          pick;
      pick = $urandom_range(0, 9);
      if (pick == 0)
         off = '0;
      else if (pick < 5)
         off = rand64() % (tol + 1);
      else if (pick < 7)
         off = tol;
      else if (pick < 9)
         off = tol + 1;
      else
         return rand64() & limit;
      if ($urandom_range(0, 1) == 1 && off <= center)
         return center - off;
      if (off <= limit - center)
         return center + off;
      if (off <= center)
         return center - off;
      return rand64() & limit;
   endfunction

   task automatic send_feature(input logic [MASS_W-1:0] mass, input logic [TIME_W-1:0] rt,
                               input logic [INT_W-1:0] inten, input logic eos);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_feature_mass <= mass;
      req_feature_time <= rt;
      req_feature_intensity <= inten;
      req_end_of_set <= eos;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      board.note_feature(mass, rt, inten, eos);
      items_sent++;
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (board.pending() > 0) @(posedge clock);
   endtask

   task automatic write_tolerances(input logic [63:0] mass_tol, input logic [63:0] time_tol);
      logic [CSR_INDEX_W-1:0] index [2];
      logic [CSR_DATA_W-1:0]  data [2];
      logic [63:0]            junk;
      junk = rand64();
      index[0] = CSR_MASS_TOL;
      data[0] = mass_tol[CSR_DATA_W-1:0];
      index[1] = CSR_TIME_TOL;
      data[1] = {junk[CSR_DATA_W-TIME_W-1:0], time_tol[TIME_W-1:0]};
      for (int k = 0; k < 2; k++) begin
         csr_valid <= 1'b1;
         csr_index <= index[k];
         csr_data <= data[k];
         @(posedge clock);
         while (csr_ready !== 1'b1) @(posedge clock);
         board.write_register(index[k], data[k]);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic run_set(input int count, input int centers, input bit loud, input bit noisy);
      logic [63:0] center_mass [8];
      logic [63:0] center_time [8];
      logic [63:0] inten;
      logic [63:0] mass;
      logic [63:0] rt;
      logic        eos;
      int          c;
      for (int k = 0; k < 8; k++) begin
         center_mass[k] = rand64() & MASS_MASK;
         center_time[k] = rand64() & TIME_MASK;
      end
      inten = loud ? INT_MASK : rand64() & INT_MASK;
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < count; i++) begin
         if (centers == 0 || (noisy && $urandom_range(0, 3) == 0)) begin
            mass = rand64() & MASS_MASK;
            rt = rand64() & TIME_MASK;
         end else begin
            c = $urandom_range(0, centers - 1);
            mass = near_value(center_mass[c], board.mass_tol, MASS_MASK);
            rt = near_value(center_time[c], board.time_tol, TIME_MASK);
         end
         if (!loud) begin
            if (noisy && $urandom_range(0, 4) == 0)
               inten = rand64() & INT_MASK;
            else
               inten = inten - (rand64() % (inten / 4 + 1));
         end
         eos = (i == count - 1) || (noisy && $urandom_range(0, 7) == 0);
         send_feature(mass[MASS_W-1:0], rt[TIME_W-1:0], inten[INT_W-1:0], eos);
      end
   endtask

   initial begin
      logic [63:0] mass_tol;
      logic [63:0] time_tol;
      board = new(MAX_CLUSTERS);
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_feature('0, '0, '1, 1'b0);
      send_feature(36'd6554, 32'd3932160, 40'd100, 1'b0);
      send_feature(36'd6555, '0, 40'd50, 1'b0);
      send_feature('0, 32'd3932161, 40'd40, 1'b0);
      send_feature('1, '1, 40'd30, 1'b0);
      send_feature('1 - 36'd6554, '1 - 32'd3932160, 40'd20, 1'b0);
      send_feature(36'd13109, '0, 40'd10, 1'b1);
      send_feature(36'h5_A5A5_A5A5, 32'h5A5A_5A5A, '0, 1'b1);
      send_feature('1, '0, '1, 1'b0);
      send_feature('1, '0, '1, 1'b0);
      send_feature(36'h0_FFFF_0000, 32'hFFFF_0000, 40'hAA_AAAA_AAAA, 1'b0);
      send_feature(36'h8_0000_FFFF, 32'h0000_FFFF, 40'h55_5555_5555, 1'b1);
      wait_drained();

      write_tolerances('0, '0);
      run_set(40, 0, 1'b0, 1'b0);
      run_set(24, 3, 1'b0, 1'b0);
      wait_drained();

      write_tolerances(MASS_MASK, TIME_MASK);
      run_set(260, 1, 1'b1, 1'b0);
      wait_drained();

      while (items_sent < 460) begin
         if ($urandom_range(0, 4) == 0) begin
            mass_tol = rand64() & MASS_MASK;
            time_tol = rand64() & TIME_MASK;
         end else begin
            mass_tol = 64'($urandom_range(0, 1 << 20));
            time_tol = 64'($urandom_range(0, 1 << 24));
         end
         write_tolerances(mass_tol, time_tol);
         repeat ($urandom_range(2, 5))
            run_set($urandom_range(1, 40), $urandom_range(1, 6), 1'b0,
                    $urandom_range(0, 5) == 0);
         wait_drained();
      end

      repeat (100) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0)
         $display("tolerance_leader_clustering_core: match");
      else
         $display("tolerance_leader_clustering_core: mismatch");
      $finish;
   end
endmodule
